FILE: design/rpn_pkg.sv
`default_nettype none
package rpn_pkg;

   localparam int DATA_W = 64;
   localparam int FRAC_W = 32;
   localparam int DVD_W  = DATA_W + FRAC_W;

   localparam logic [DATA_W-1:0] SIGN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] MAX_POS  = {1'b0, {(DATA_W-1){1'b1}}};

   localparam logic [2:0] OP_NUM   = 3'd0;
   localparam logic [2:0] OP_ADD   = 3'd1;
   localparam logic [2:0] OP_SUB   = 3'd2;
   localparam logic [2:0] OP_MUL   = 3'd3;
   localparam logic [2:0] OP_DIV   = 3'd4;
   localparam logic [2:0] OP_MOD   = 3'd5;
   localparam logic [2:0] OP_PRINT = 3'd6;
   localparam logic [2:0] OP_UNK   = 3'd7;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_DIV_ZERO = 3'd1;
   localparam logic [2:0] ERR_MOD_FRAC = 3'd2;
   localparam logic [2:0] ERR_MOD_ZERO = 3'd3;
   localparam logic [2:0] ERR_UNKNOWN  = 3'd4;

   typedef struct packed {
      logic done;
      logic ovf;
   } div_stat_type;

   function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + 1'b1) : v;
   endfunction

   // apply sign to a magnitude, saturating
   function automatic logic [DATA_W-1:0] pack_signed(input logic [DATA_W-1:0] mag,
                                                     input logic neg, input logic ovf);
      logic [DATA_W-1:0] r;
      if (neg) begin
         r = (ovf || mag > SIGN_VAL) ? SIGN_VAL : (~mag + 1'b1);
      end else begin
         r = (ovf || mag > MAX_POS) ? MAX_POS : mag;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/rpn_if.sv
`default_nettype none
interface rpn_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic signed [63:0] operand_value;

   modport source (output valid, op, operand_value, input ready);
   modport sink   (input valid, op, operand_value, output ready);
endinterface

interface rpn_rsp_if;
   logic               valid;
   logic               ready;
   logic               print_valid;
   logic signed [63:0] print_value;
   logic [1:0]         underflow_count;
   logic               overflow;
   logic [2:0]         error_code;
   logic [7:0]         depth;

   modport source (output valid, print_valid, print_value, underflow_count, overflow,
                   error_code, depth, input ready);
   modport sink   (input valid, print_valid, print_value, underflow_count, overflow,
                   error_code, depth, output ready);
endinterface
`default_nettype wire

FILE: design/rpn_div.sv
`default_nettype none
module rpn_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [rpn_pkg::DVD_W-1:0] dividend,
   input  wire logic [rpn_pkg::DATA_W-1:0] divisor,
   output rpn_pkg::div_stat_type          status,
   output logic [rpn_pkg::DATA_W-1:0]     quot,
   output logic [rpn_pkg::DATA_W-1:0]     remainder
);
   import rpn_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  dvd_ff;
   logic [DATA_W-1:0] dsr_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] q_ff;
   logic              ovf_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic [DATA_W:0]   rem_sh;
   logic              fits;

   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits   = rem_sh >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && cnt_ff == CNT_W'(1);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
            q_ff    <= '0;
            ovf_ff  <= 1'b0;
         end else if (busy_ff) begin
            // one quotient bit per cycle
            dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
            ovf_ff <= ovf_ff | q_ff[DATA_W-1];
            q_ff   <= {q_ff[DATA_W-2:0], fits};
            rem_ff <= fits ? DATA_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[DATA_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign status.done = done_ff;
   assign status.ovf  = ovf_ff;
   assign quot        = q_ff;
   assign remainder   = rem_ff;
endmodule
`default_nettype wire

FILE: design/rpn_stack_evaluator.sv
// RPN stack evaluator.
// req channel: one decoded token per request (op, operand_value in Q31.32).
// rsp channel: exactly one response per request with print data, underflow
// count, overflow flag, error code and the stack depth after the token.
// Both channels use valid/ready; a transfer happens when both are high.
// One token is processed at a time. Divide and modulo run on the bit-serial
// divider, which takes 96 steps.
// The stack sits in a single-port-write memory with a registered read;
// pops and pushes are sequenced so a read never overlaps a write.
// The response is held in an output register: the next request is taken
// while a finished response still waits for rsp ready. If the receiver
// stalls, the following token finishes and then waits for the slot.
// Synchronous reset empties the stack (depth 0) and drops any pending
// response; stack memory contents are not cleared and need no clearing.
`default_nettype none
module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = 128
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rpn_req_if.sink    req_if,
   rpn_rsp_if.source  rsp_if
);
   import rpn_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_POPY, S_GETY, S_POPX, S_GETX, S_EXEC, S_MUL, S_MACC,
      S_MULPK, S_DIVGO, S_DIVWAIT, S_PUSH, S_FIN
   } state_type;

   state_type         state_ff;
   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic [CW-1:0]     cnt_ff;
   logic [2:0]        op_ff;
   logic [DATA_W-1:0] x_ff, y_ff, res_ff, ma_ff, mb_ff;
   logic              got_ff, neg_ff;
   logic [1:0]        uf_ff;
   logic              ovf_ff, pvalid_ff;
   logic [2:0]        err_ff;
   logic [DATA_W-1:0] pv_ff;
   logic [1:0]        idx_ff;
   logic [DATA_W-1:0] p_ff;
   logic [2*DATA_W-1:0] acc_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [DATA_W-1:0] dsr_ff;

   logic              rsp_valid_ff, rsp_pvalid_ff, rsp_ovf_ff;
   logic [DATA_W-1:0] rsp_pv_ff;
   logic [1:0]        rsp_uf_ff;
   logic [2:0]        rsp_err_ff;
   logic [7:0]        rsp_depth_ff;

   logic [AW-1:0]     rd_addr;
   logic              full;
   logic              slot_free;
   logic [DATA_W-1:0] sum, diff, rdval;
   logic [1:0]        sh;
   logic [DATA_W-1:0] qv, rv;
   div_stat_type      div_stat;

   assign rd_addr   = AW'(cnt_ff - 1'b1);
   assign full      = 32'(cnt_ff) >= STACK_DEPTH;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign sum       = x_ff + y_ff;
   assign diff      = x_ff - y_ff;
   assign rdval     = got_ff ? rdata_ff : '0;
   assign sh        = 2'(idx_ff[1]) + 2'(idx_ff[0]);

   rpn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == S_DIVGO),
      .dividend  (dvd_ff),
      .divisor   (dsr_ff),
      .status    (div_stat),
      .quot      (qv),
      .remainder (rv)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_PUSH && !full) begin
         mem[cnt_ff[AW-1:0]] <= res_ff;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  op_ff     <= req_if.op;
                  res_ff    <= req_if.operand_value;
                  uf_ff     <= '0;
                  ovf_ff    <= 1'b0;
                  err_ff    <= ERR_NONE;
                  pvalid_ff <= 1'b0;
                  pv_ff     <= '0;
                  priority case (req_if.op)
                     OP_NUM:  state_ff <= S_PUSH;
                     OP_UNK: begin
                        err_ff   <= ERR_UNKNOWN;
                        state_ff <= S_FIN;
                     end
                     default: state_ff <= S_POPY;
                  endcase
               end
            end
            S_POPY, S_POPX: begin
               got_ff <= cnt_ff != '0;
               if (cnt_ff != '0) begin
                  cnt_ff <= cnt_ff - 1'b1;
               end else begin
                  uf_ff <= uf_ff + 1'b1;
               end
               state_ff <= (state_ff == S_POPY) ? S_GETY : S_GETX;
            end
            S_GETY: begin
               y_ff <= rdval;
               if (op_ff == OP_PRINT) begin
                  pvalid_ff <= 1'b1;
                  pv_ff     <= rdval;
                  state_ff  <= S_FIN;
               end else if (op_ff == OP_DIV && rdval == '0) begin
                  err_ff   <= ERR_DIV_ZERO;
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_POPX;
               end
            end
            S_GETX: begin
               x_ff     <= rdval;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               ma_ff    <= magnitude(x_ff);
               mb_ff    <= magnitude(y_ff);
               // modulo takes the sign of the dividend alone
               neg_ff   <= (op_ff == OP_MOD) ? x_ff[DATA_W-1]
                                             : (x_ff[DATA_W-1] ^ y_ff[DATA_W-1]);
               acc_ff   <= '0;
               idx_ff   <= '0;
               state_ff <= S_PUSH;
               priority case (op_ff)
                  OP_ADD: begin
                     res_ff <= (!(x_ff[DATA_W-1] ^ y_ff[DATA_W-1]) &&
                                (sum[DATA_W-1] ^ x_ff[DATA_W-1]))
                               ? (x_ff[DATA_W-1] ? SIGN_VAL : MAX_POS) : sum;
                  end
                  OP_SUB: begin
                     res_ff <= ((x_ff[DATA_W-1] ^ y_ff[DATA_W-1]) &&
                                (diff[DATA_W-1] ^ x_ff[DATA_W-1]))
                               ? (x_ff[DATA_W-1] ? SIGN_VAL : MAX_POS) : diff;
                  end
                  OP_MUL: state_ff <= S_MUL;
                  OP_DIV: begin
                     dvd_ff   <= {magnitude(x_ff), {FRAC_W{1'b0}}};
                     dsr_ff   <= magnitude(y_ff);
                     state_ff <= S_DIVGO;
                  end
                  default: begin
                     // modulo: whole numbers only, sign follows the dividend
                     dvd_ff <= DVD_W'(magnitude(x_ff) >> FRAC_W);
                     dsr_ff <= magnitude(y_ff) >> FRAC_W;
                     if (x_ff[FRAC_W-1:0] != '0 || y_ff[FRAC_W-1:0] != '0) begin
                        err_ff   <= ERR_MOD_FRAC;
                        state_ff <= S_FIN;
                     end else if (y_ff == '0) begin
                        err_ff   <= ERR_MOD_ZERO;
                        state_ff <= S_FIN;
                     end else begin
                        state_ff <= S_DIVGO;
                     end
                  end
               endcase
            end
            S_MUL: begin
               p_ff <= (idx_ff[1] ? ma_ff[DATA_W-1:FRAC_W] : ma_ff[FRAC_W-1:0]) *
                       (idx_ff[0] ? mb_ff[DATA_W-1:FRAC_W] : mb_ff[FRAC_W-1:0]);
               state_ff <= S_MACC;
            end
            S_MACC: begin
               acc_ff   <= acc_ff + ({{DATA_W{1'b0}}, p_ff} << {sh, 5'b0});
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= (idx_ff == 2'd3) ? S_MULPK : S_MUL;
            end
            S_MULPK: begin
               res_ff   <= pack_signed(acc_ff[DVD_W-1:FRAC_W], neg_ff,
                                       |acc_ff[2*DATA_W-1:DVD_W]);
               state_ff <= S_PUSH;
            end
            S_DIVGO: state_ff <= S_DIVWAIT;
            S_DIVWAIT: begin
               if (div_stat.done) begin
                  res_ff <= (op_ff == OP_DIV)
                            ? pack_signed(qv, neg_ff, div_stat.ovf)
                            : pack_signed({rv[FRAC_W-1:0], {FRAC_W{1'b0}}}, neg_ff, 1'b0);
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (!full) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  ovf_ff <= 1'b1;
               end
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (slot_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_pvalid_ff <= pvalid_ff;
                  rsp_pv_ff     <= pv_ff;
                  rsp_uf_ff     <= uf_ff;
                  rsp_ovf_ff    <= ovf_ff;
                  rsp_err_ff    <= err_ff;
                  rsp_depth_ff  <= (32'(cnt_ff) > 32'd255) ? 8'd255 : 8'(cnt_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_if.ready           = state_ff == S_IDLE;
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.print_valid     = rsp_pvalid_ff;
   assign rsp_if.print_value     = rsp_pv_ff;
   assign rsp_if.underflow_count = rsp_uf_ff;
   assign rsp_if.overflow        = rsp_ovf_ff;
   assign rsp_if.error_code      = rsp_err_ff;
   assign rsp_if.depth           = rsp_depth_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= STACK_DEPTH)
      else $error("stack count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && !full) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("push did not advance stack count");

   a_print_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pvalid_ff) |-> (rsp_err_ff == ERR_NONE && !rsp_ovf_ff))
      else $error("print response carries an error");
endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
   import rpn_pkg::*;

   localparam int DEPTH_MAX = 128;
   localparam int RANDOM_TOKENS = 1400;
   localparam longint CYCLE_LIMIT = 10000000;

   typedef struct packed {
      logic        print_valid;
      logic [63:0] print_value;
      logic [1:0]  underflow_count;
      logic        overflow;
      logic [2:0]  error_code;
      logic [7:0]  depth;
   } rsp_fields_type;

   typedef struct {
      logic [2:0]     op;
      logic [63:0]    value;
      bit             has_exp;
      rsp_fields_type exp;
   } token_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpn_req_if req_if ();
   rpn_rsp_if rsp_if ();

   rpn_stack_evaluator #(.STACK_DEPTH(DEPTH_MAX)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // Predictor state.
   logic [63:0] model_stack[DEPTH_MAX];
   int          model_count;
   int          pop_misses;
   bit          push_dropped;

   rsp_fields_type pending_rsp[$];
   int          error_total;
   longint      cycle_count;
   int          rsp_seen;
   int          op_hits[8];

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] abs_val(logic [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   function automatic logic [63:0] sign_sat(logic [63:0] mag, logic neg, logic ovf);
      if (neg) return (ovf || mag > SIGN_VAL) ? SIGN_VAL : (~mag + 64'd1);
      return (ovf || mag > MAX_POS) ? MAX_POS : mag;
   endfunction

   function automatic logic [63:0] q_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SIGN_VAL : MAX_POS;
      return s;
   endfunction

   function automatic logic [63:0] q_sub(logic [63:0] a, logic [63:0] b);
      logic [63:0] d;
      d = a - b;
      if (a[63] != b[63] && d[63] != a[63]) return a[63] ? SIGN_VAL : MAX_POS;
      return d;
   endfunction

   function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = abs_val(a) * abs_val(b);
      return sign_sat(p[95:32], a[63] ^ b[63], p[127:96] != 0);
   endfunction

   function automatic logic [63:0] q_div(logic [63:0] a, logic [63:0] b);
      logic [95:0] q;
      logic [95:0] num;
      num = {abs_val(a), 32'd0};
      q = num / {32'd0, abs_val(b)};
      return sign_sat(q[63:0], a[63] ^ b[63], q[95:64] != 0);
   endfunction

   function automatic logic [63:0] stack_pop();
      if (model_count > 0) begin
         model_count--;
         return model_stack[model_count];
      end
      pop_misses++;
      return 64'd0;
   endfunction

   function automatic void stack_push(logic [63:0] v);
      if (model_count < DEPTH_MAX) begin
         model_stack[model_count] = v;
         model_count++;
      end else begin
         push_dropped = 1'b1;
      end
   endfunction

   function automatic rsp_fields_type evaluate_token(logic [2:0] op, logic [63:0] v);
      rsp_fields_type r;
      logic [63:0] x, y, ix, iy;
      r = '0;
      pop_misses = 0;
      push_dropped = 1'b0;
      case (op)
         OP_NUM: stack_push(v);
         OP_ADD: begin
            y = stack_pop(); x = stack_pop(); stack_push(q_add(x, y));
         end
         OP_SUB: begin
            y = stack_pop(); x = stack_pop(); stack_push(q_sub(x, y));
         end
         OP_MUL: begin
            y = stack_pop(); x = stack_pop(); stack_push(q_mul(x, y));
         end
         OP_DIV: begin
            y = stack_pop();
            if (y != 0) begin
               x = stack_pop(); stack_push(q_div(x, y));
            end else begin
               r.error_code = ERR_DIV_ZERO;
            end
         end
         OP_MOD: begin
            y = stack_pop(); x = stack_pop();
            if (x[31:0] != 0 || y[31:0] != 0) begin
               r.error_code = ERR_MOD_FRAC;
            end else if (y == 0) begin
               r.error_code = ERR_MOD_ZERO;
            end else begin
               ix = abs_val(x) >> 32;
               iy = abs_val(y) >> 32;
               stack_push(sign_sat((ix % iy) << 32, x[63], 1'b0));
            end
         end
         OP_PRINT: begin
            r.print_value = stack_pop();
            r.print_valid = 1'b1;
         end
         default: r.error_code = ERR_UNKNOWN;
      endcase
      r.underflow_count = pop_misses[1:0];
      r.overflow = push_dropped;
      r.depth = model_count[7:0];
      return r;
   endfunction

   // Random Q31.32 value: often an integer, sometimes an extreme.
   function automatic logic [63:0] rand_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = MAX_POS;
         1: v = SIGN_VAL;
         2: v = 64'd0;
         3, 4: v = {{30{v[63]}}, v[33:32], 32'd0};
         5: v = {v[63:32], 32'd0};
         6: v = {{16{v[63]}}, v[47:0]};
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_token(logic [2:0] op, logic [63:0] v, bit has_exp,
                             rsp_fields_type exp_rsp);
      rsp_fields_type pred;
      pred = evaluate_token(op, v);
      if (has_exp && pred != exp_rsp) begin
         $error("directed row op=%0d: table %h predictor %h", op, exp_rsp, pred);
         error_total++;
      end
      op_hits[op]++;
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.operand_value <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_rsp.push_back(pred);
   endtask

   task automatic idle_cycles(int n);
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic rsp_fields_type mk(logic pv, logic [63:0] pval, logic [1:0] uf,
                                         logic ov, logic [2:0] err, logic [7:0] d);
      return '{pv, pval, uf, ov, err, d};
   endfunction

   // Response checker and receiver stall pattern.
   initial begin
      rsp_fields_type want;
      logic [7:0] stall_pat;
      rsp_if.ready <= 1'b0;
      stall_pat = 8'hff;
      @(posedge clock);
      forever begin
         @(posedge clock);
         cycle_count++;
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               $error("response with no request outstanding");
               error_total++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_if.print_valid !== want.print_valid) begin
                  $error("print_valid exp %0d got %0d", want.print_valid,
                         rsp_if.print_valid);
                  error_total++;
               end
               if (rsp_if.print_value !== want.print_value) begin
                  $error("print_value exp %h got %h", want.print_value,
                         rsp_if.print_value);
                  error_total++;
               end
               if (rsp_if.underflow_count !== want.underflow_count) begin
                  $error("underflow_count exp %0d got %0d", want.underflow_count,
                         rsp_if.underflow_count);
                  error_total++;
               end
               if (rsp_if.overflow !== want.overflow) begin
                  $error("overflow exp %0d got %0d", want.overflow, rsp_if.overflow);
                  error_total++;
               end
               if (rsp_if.error_code !== want.error_code) begin
                  $error("error_code exp %0d got %0d", want.error_code,
                         rsp_if.error_code);
                  error_total++;
               end
               if (rsp_if.depth !== want.depth) begin
                  $error("depth exp %0d got %0d", want.depth, rsp_if.depth);
                  error_total++;
               end
            end
         end
         if (cycle_count % 512 == 0) stall_pat = 8'($urandom);
         if (cycle_count % 2048 < 400) rsp_if.ready <= 1'b1;
         else rsp_if.ready <= stall_pat[cycle_count % 8];
         if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   token_row_type directed[$];

   initial begin
      rsp_fields_type none;
      int burst, mode, depth_goal;
      logic [2:0] op;
      none = '0;
      error_total = 0;
      cycle_count = 0;
      rsp_seen = 0;
      model_count = 0;
      req_if.valid <= 1'b0;
      req_if.op <= OP_NUM;
      req_if.operand_value <= '0;

      directed = '{
         '{OP_PRINT, 64'd0, 1'b1, mk(1'b1, 64'd0, 2'd1, 1'b0, ERR_NONE, 8'd0)},
         '{OP_ADD,   64'd0, 1'b1, mk(1'b0, 64'd0, 2'd2, 1'b0, ERR_NONE, 8'd1)},
         '{OP_PRINT, 64'd0, 1'b1, mk(1'b1, 64'd0, 2'd0, 1'b0, ERR_NONE, 8'd0)},
         '{OP_DIV,   64'd0, 1'b1, mk(1'b0, 64'd0, 2'd1, 1'b0, ERR_DIV_ZERO, 8'd0)},
         '{OP_MOD,   64'd0, 1'b1, mk(1'b0, 64'd0, 2'd2, 1'b0, ERR_MOD_ZERO, 8'd0)},
         '{OP_UNK,   64'd0, 1'b1, mk(1'b0, 64'd0, 2'd0, 1'b0, ERR_UNKNOWN, 8'd0)},
         '{OP_NUM,   MAX_POS, 1'b1, mk(1'b0, 64'd0, 2'd0, 1'b0, ERR_NONE, 8'd1)},
         '{OP_NUM,   MAX_POS, 1'b1, mk(1'b0, 64'd0, 2'd0, 1'b0, ERR_NONE, 8'd2)},
         '{OP_ADD,   64'd0, 1'b1, mk(1'b0, 64'd0, 2'd0, 1'b0, ERR_NONE, 8'd1)},
         '{OP_PRINT, 64'd0, 1'b1, mk(1'b1, MAX_POS, 2'd0, 1'b0, ERR_NONE, 8'd0)},
         '{OP_NUM,   SIGN_VAL, 1'b0, none},
         '{OP_NUM,   64'h0000_0001_0000_0000, 1'b0, none},
         '{OP_SUB,   64'd0, 1'b0, none},
         '{OP_NUM,   SIGN_VAL, 1'b0, none},
         '{OP_MUL,   64'd0, 1'b0, none},
         '{OP_NUM,   64'hFFFF_FFFD_0000_0000, 1'b0, none},
         '{OP_NUM,   64'h0000_0002_0000_0000, 1'b0, none},
         '{OP_MOD,   64'd0, 1'b0, none},
         '{OP_NUM,   64'h0000_0000_8000_0000, 1'b0, none},
         '{OP_NUM,   64'h0000_0002_0000_0000, 1'b0, none},
         '{OP_MOD,   64'd0, 1'b1, mk(1'b0, 64'd0, 2'd0, 1'b0, ERR_MOD_FRAC, 8'd2)},
         '{OP_NUM,   64'h0000_0003_0000_0000, 1'b0, none},
         '{OP_DIV,   64'd0, 1'b0, none},
         '{OP_NUM,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, none},
         '{OP_DIV,   64'd0, 1'b0, none}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_token(directed[i].op, directed[i].value, directed[i].has_exp,
                    directed[i].exp);

      // Fill the stack past full once, then drain it by printing.
      for (int i = 0; i < DEPTH_MAX + 3; i++) send_token(OP_NUM, rand_value(), 1'b0, none);
      idle_cycles(1);
      while (pending_rsp.size() != 0) @(posedge clock);
      for (int i = 0; i < DEPTH_MAX + 2; i++) send_token(OP_PRINT, 64'd0, 1'b0, none);

      // Random: mostly well-formed, depth-steered sequences with random gaps.
      depth_goal = 4;
      for (int n = 0; n < RANDOM_TOKENS; ) begin
         burst = $urandom_range(1, 24);
         if ($urandom_range(0, 19) == 0) depth_goal = $urandom_range(0, DEPTH_MAX + 2);
         for (int b = 0; b < burst; b++, n++) begin
            mode = $urandom_range(0, 99);
            if (mode < 5) op = 3'($urandom_range(0, 7));
            else if (model_count < 2 || (model_count < depth_goal && mode < 55)) op = OP_NUM;
            else op = 3'($urandom_range(1, 6));
            send_token(op, rand_value(), 1'b0, none);
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 30));
      end
      req_if.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      $display("tb: %0d responses checked; ops num/add/sub/mul/div/mod/print/unk = ",
               rsp_seen);
      $display("   %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d", op_hits[0], op_hits[1], op_hits[2],
               op_hits[3], op_hits[4], op_hits[5], op_hits[6], op_hits[7]);
      if (error_total == 0 && pending_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire
